### src/gated_activation_chunk_unit_defines.svh
// assertion macros shared by the gated activation chunk unit
`ifndef GATED_ACTIVATION_CHUNK_UNIT_DEFINES_SVH
`define GATED_ACTIVATION_CHUNK_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gac assertion failed");
// next-cycle implication
`define GAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gac assertion failed");
`else
`define GAC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define GAC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/gac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gac_pkg;

    localparam int DATA_W      = 16;
    localparam int TAB_ENTRIES = 256;
    localparam int TAB_SHIFT   = 15 - $clog2(TAB_ENTRIES);
    localparam int CFG_AW      = 3;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint GELU_C1 = 836643;
    localparam longint GELU_C2 = 46887;

    // register indexes
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    // gate modes
    localparam logic MODE_GELU = 1'b0;
    localparam logic MODE_SILU = 1'b1;

    typedef logic [15:0] gac_tab_t [0:TAB_ENTRIES];

    // control from the top level to the math unit
    typedef struct packed {
        logic start;
        logic mode;
        logic take;
    } gac_ctl_t;

    // status from the math unit
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DATA_W-1:0]   value;
    } gac_sts_t;

    // unsigned quotient by shift and subtract, used when building the tables
    function automatic longint unsigned gac_udiv(input longint unsigned n,
                                                 input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-16 g) in Q30, taylor series then four squarings
    function automatic longint unsigned gac_exp_neg16(input longint unsigned g);
        longint          term;
        longint          sum;
        longint          num;
        longint unsigned d;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 16; k++) begin
            num  = -((term * longint'(g)) / Q30_ONE);
            // truncating division toward zero
            if (num < 0) term = -longint'(gac_udiv(64'(-num), 64'(k)));
            else         term = longint'(gac_udiv(64'(num), 64'(k)));
            sum  = sum + term;
        end
        if (sum < 0) sum = 0;
        d = longint'(sum);
        for (int k = 0; k < 4; k++) d = (d * d + 64'd536870912) >> 30;
        return d;
    endfunction

    // sigmoid or tanh table in unsigned Q1.15
    function automatic gac_tab_t gac_build_tab(input logic is_tanh);
        gac_tab_t        t;
        longint unsigned g;
        longint unsigned e1;
        longint unsigned e2;
        longint unsigned den;
        for (int i = 0; i <= TAB_ENTRIES; i++) begin
            g  = (longint'(i) << 30) / (2 * TAB_ENTRIES);
            e1 = gac_exp_neg16(g);
            e2 = (e1 * e1 + 64'd536870912) >> 30;
            if (is_tanh) begin
                den  = Q30_ONE + e2;
                t[i] = 16'(gac_udiv(((Q30_ONE - e2) << 15) + den / 2, den));
            end else begin
                den  = Q30_ONE + e1;
                t[i] = 16'(gac_udiv((64'd1 << 45) + den / 2, den));
            end
        end
        return t;
    endfunction

    localparam gac_tab_t TANH_TAB = gac_build_tab(1'b1);
    localparam gac_tab_t SIG_TAB  = gac_build_tab(1'b0);

endpackage
`default_nettype wire

### src/gac_math.sv
`timescale 1ns / 1ps
`default_nettype none
module gac_math import gac_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gac_ctl_t          ctl,
    input  wire logic [DATA_W-1:0] second_in,
    input  wire logic [DATA_W-1:0] first_in,
    output gac_sts_t               sts
);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_P1   = 4'd1;
    localparam logic [3:0] M_P2   = 4'd2;
    localparam logic [3:0] M_P3   = 4'd3;
    localparam logic [3:0] M_P4   = 4'd4;
    localparam logic [3:0] M_P5   = 4'd5;
    localparam logic [3:0] M_P6   = 4'd6;
    localparam logic [3:0] M_P7   = 4'd7;
    localparam logic [3:0] M_P8   = 4'd8;
    localparam logic [3:0] M_P9   = 4'd9;
    localparam logic [3:0] M_DONE = 4'd10;

    logic [3:0]               st_reg, st_next;
    logic                     mode_reg;
    logic signed [15:0]       x_reg;
    logic signed [15:0]       f_reg;
    logic signed [63:0]       acc_reg, acc_next;
    logic [18:0]              mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [15:0]              lo_reg;
    logic signed [16:0]       diff_reg;
    logic [14:0]              frac_reg;
    logic                     sat_reg;
    logic signed [17:0]       gate_reg, gate_next;
    logic signed [19:0]       prod_reg, prod_next;
    logic [15:0]              res_reg, res_next;

    logic signed [63:0]       inner;
    logic signed [19:0]       u;
    logic [7:0]               idx;
    logic [15:0]              lo_val;
    logic [15:0]              hi_val;
    logic signed [31:0]       interp_prod;
    logic signed [16:0]       t_val;
    logic signed [35:0]       gate_prod;
    logic signed [35:0]       fin_prod;
    logic signed [23:0]       fin_rnd;
    logic signed [16:0]       f_abs;

    // sequencing of the shared arithmetic steps
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            M_IDLE:  if (ctl.start) st_next = M_P1;
            M_P1:    st_next = (mode_reg == MODE_SILU) ? M_P6 : M_P2;
            M_P2:    st_next = M_P3;
            M_P3:    st_next = M_P4;
            M_P4:    st_next = M_P5;
            M_P5:    st_next = M_P6;
            M_P6:    st_next = M_P7;
            M_P7:    st_next = M_P8;
            M_P8:    st_next = M_P9;
            M_P9:    st_next = M_DONE;
            M_DONE:  if (ctl.take) st_next = M_IDLE;
            default: st_next = M_IDLE;
        endcase
    end

    // datapath for each step
    always_comb begin
        acc_next  = acc_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        gate_next = gate_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        f_abs     = $signed(first_in) < 0 ? -17'(signed'(first_in)) : 17'(signed'(first_in));
        inner     = (64'(x_reg) <<< 24) + ((acc_reg + 64'sd524288) >>> 20);
        u         = 20'((acc_reg + 64'sd8796093022208) >>> 44);
        idx       = mag_reg[14:7];
        lo_val    = (mode_reg == MODE_SILU) ? SIG_TAB[idx] : TANH_TAB[idx];
        hi_val    = (mode_reg == MODE_SILU) ? SIG_TAB[9'(idx) + 9'd1]
                                            : TANH_TAB[9'(idx) + 9'd1];
        interp_prod = diff_reg * $signed({17'd0, frac_reg});
        t_val     = sat_reg ? $signed({1'b0, lo_reg})
                            : $signed({1'b0, lo_reg}) + 17'((interp_prod + 32'sd16384) >>> 15);
        gate_prod = (mode_reg == MODE_SILU) ? 36'(f_reg) * 36'(gate_reg)
                                            : 36'(x_reg) * 36'(gate_reg);
        fin_prod  = (mode_reg == MODE_SILU) ? 36'(prod_reg) * 36'(x_reg)
                                            : 36'(prod_reg) * 36'(f_reg);
        fin_rnd   = 24'((fin_prod + 36'sd2048) >>> 12);
        case (st_reg)
            M_P1: begin
                acc_next = 64'(x_reg) * 64'(x_reg);
                mag_next = 19'(f_abs);
                neg_next = first_in[15];
            end
            M_P2: acc_next = 64'($signed(acc_reg[31:0])) * 64'(x_reg);
            M_P3: acc_next = 64'($signed(acc_reg[47:0])) * GELU_C2;
            M_P4: acc_next = inner * GELU_C1;
            M_P5: begin
                mag_next = u < 0 ? 19'(-u) : 19'(u);
                neg_next = u < 0;
            end
            M_P7: begin
                if (mode_reg == MODE_SILU)
                    gate_next = neg_reg ? 18'sd32768 - 18'(t_val) : 18'(t_val);
                else
                    gate_next = neg_reg ? 18'sd32768 - 18'(t_val) : 18'sd32768 + 18'(t_val);
            end
            M_P8: begin
                if (mode_reg == MODE_SILU) prod_next = 20'((gate_prod + 36'sd16384) >>> 15);
                else                       prod_next = 20'((gate_prod + 36'sd32768) >>> 16);
            end
            M_P9: begin
                if (fin_rnd > 24'sd32767)       res_next = 16'h7fff;
                else if (fin_rnd < -24'sd32768) res_next = 16'h8000;
                else                            res_next = fin_rnd[15:0];
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= M_IDLE;
        else          st_reg <= st_next;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (st_reg == M_IDLE && ctl.start) begin
            mode_reg <= ctl.mode;
            x_reg    <= $signed(second_in);
        end
        if (st_reg == M_P1) f_reg <= $signed(first_in);
        if (st_reg == M_P6) begin
            sat_reg  <= |mag_reg[18:15];
            lo_reg   <= (|mag_reg[18:15])
                        ? ((mode_reg == MODE_SILU) ? SIG_TAB[TAB_ENTRIES] : TANH_TAB[TAB_ENTRIES])
                        : lo_val;
            diff_reg <= $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});
            frac_reg <= {mag_reg[TAB_SHIFT-1:0], 8'd0};
        end
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        gate_reg <= gate_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign sts.busy  = (st_reg != M_IDLE);
    assign sts.done  = (st_reg == M_DONE);
    assign sts.value = res_reg;

endmodule
`default_nettype wire

### src/gated_activation_chunk_unit.sv
// gated activation over chunks of a stream of signed Q3.12 words
// input channel s_*: tdata = sample_value, tlast = final_item (end of tensor)
// result channel m_*: tdata = gated_value, tlast = final_result
// config over apb: 0x0 chunk_width (11 bits), 0x4 gate_mode (0 gelu, 1 silu)
// first-half words of a chunk go into an on-chip buffer and give no result;
// each second-half word reads its partner and starts the shared math unit
// a producing word runs the math unit through its steps, of which silu mode
// skips those that form the tanh argument, and its result shows on m_tvalid
// once the output register takes it from the math unit
// one producing word in flight at a time, as s_tready stays low while the
// math unit is busy; buffer-only words one per cycle while it is idle
// the output register lets the next word be taken while a result waits;
// a stalled receiver holds the math unit in its done state, and s_tready
// stays low; reset clears position, registers (width 2, gelu) and handshakes,
// the buffer itself holds garbage until written
`timescale 1ns / 1ps
`default_nettype none
`include "gated_activation_chunk_unit_defines.svh"
module gated_activation_chunk_unit import gac_pkg::*; #(
    parameter int MAX_CHUNK = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // sample_value [15:0]
    input  wire logic [15:0]       s_tdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_tlast,
    // gated_value [15:0]
    output logic [15:0]            m_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic                   m_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DEPTH = MAX_CHUNK / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_CHUNK);
    localparam int WW    = $clog2(MAX_CHUNK + 1);

    logic [10:0]     width_reg;
    logic            mode_reg;
    logic [PW-1:0]   pos_reg, pos_next;
    logic            fin_reg;
    logic            m_valid_reg;
    logic [15:0]     m_data_reg;
    logic            m_last_reg;
    logic [15:0]     mem [0:DEPTH-1];
    logic [15:0]     mem_q;

    logic [WW-1:0]   w_eff;
    logic [WW-1:0]   half;
    logic            accept;
    logic            do_store;
    logic            do_calc;
    logic            cfg_wr;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    gac_ctl_t        ctl;
    gac_sts_t        sts;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : {21'd0, width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd2;
            mode_reg  <= MODE_GELU;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) width_reg <= pwdata[10:0];
            else                       mode_reg  <= pwdata[0];
        end
    end

    // chunk position and split decision
    assign w_eff    = (32'(width_reg) > MAX_CHUNK) ? WW'(MAX_CHUNK) : WW'(width_reg);
    assign half     = w_eff >> 1;
    assign accept   = s_tvalid && s_tready;
    assign do_store = accept && (32'(pos_reg) < 32'(half));
    assign do_calc  = accept && !(32'(pos_reg) < 32'(half))
                      && (32'(pos_reg) < 32'(half) * 2);
    assign wr_addr  = AW'(pos_reg);
    assign rd_addr  = AW'(32'(pos_reg) - 32'(half));
    assign pos_next = (s_tlast || (32'(pos_reg) + 1 >= 32'(w_eff))) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn)    pos_reg <= '0;
        else if (accept) pos_reg <= pos_next;
    end

    // first-half buffer, registered read
    always_ff @(posedge aclk) begin
        if (do_store) mem[wr_addr] <= s_tdata;
        if (do_calc)  mem_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (do_calc) fin_reg <= s_tlast;
    end

    // math unit
    assign s_tready  = !sts.busy;
    assign ctl.start = do_calc;
    assign ctl.mode  = mode_reg;
    assign ctl.take  = sts.done && (!m_valid_reg || m_tready);

    gac_math u_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .second_in (s_tdata),
        .first_in  (mem_q),
        .sts       (sts)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn)                 m_valid_reg <= 1'b0;
        else if (ctl.take)            m_valid_reg <= 1'b1;
        else if (m_tready)            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            m_data_reg <= sts.value;
            m_last_reg <= fin_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `GAC_ASSERT_NEXT(a_start_busy, aclk, aresetn, ctl.start, sts.busy)
    `GAC_ASSERT_NEXT(a_done_hold, aclk, aresetn, sts.done && !ctl.take, sts.done && $stable(sts.value))
    `GAC_ASSERT_IMPL(a_no_store_busy, aclk, aresetn, sts.busy, !do_store && !do_calc)

endmodule
`default_nettype wire
